// ----- sv/ial_pkg.sv -----
`timescale 1ns / 1ps
// ial_pkg: shared sizes, operation and status codes, and the control and
// status structs between the list controller and its datapath. No dependencies.

package ial_pkg;

    localparam int DEPTH    = 64;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 7;
    localparam int COUNT_W  = 7;
    // compare width, one bit of headroom over every operand
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
    localparam logic [FUNC_W-1:0] FN_GET    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_EDIT   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DELETE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_APPEND,
        ACT_INSERT,
        ACT_GET,
        ACT_EDIT,
        ACT_DELETE
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_GET_RD,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic get_cap;
        logic sh_read;
        logic sh_write;
        logic sh_tail;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        act_t act;
        logic more;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/ial_ctrl.sv -----
`timescale 1ns / 1ps
// ial_ctrl: sequencer for one request at a time, drives datapath commands.
// Depends on ial_pkg.

module ial_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ial_pkg::dp_status_t    dp_status,
    output ial_pkg::ctrl_cmd_t     cmd
);
    import ial_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.exec = 1'b1;
                unique case (dp_status.act)
                    ACT_GET:                state_next = S_GET_RD;
                    ACT_INSERT, ACT_DELETE: state_next = S_SHIFT_RD;
                    default:                state_next = S_FINISH;
                endcase
            end
            S_GET_RD:
            begin
                cmd.get_cap = 1'b1;
                state_next  = S_FINISH;
            end
            S_SHIFT_RD:
            begin
                if (dp_status.more)
                begin
                    cmd.sh_read = 1'b1;
                    state_next  = S_SHIFT_WR;
                end
                else
                begin
                    cmd.sh_tail = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.sh_write = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_FINISH:
            begin
                if (dp_status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/ial_dpath.sv -----
`timescale 1ns / 1ps
// ial_dpath: entry memory, fill count, capacity register, request and result
// registers, shift index. Depends on ial_pkg.

module ial_dpath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  ial_pkg::ctrl_cmd_t                cmd,
    output ial_pkg::dp_status_t               dp_status,
    input  logic                              cfg_valid,
    input  logic [ial_pkg::CAP_W-1:0]         cfg_data,
    input  logic [ial_pkg::FUNC_W-1:0]        func,
    input  logic [ial_pkg::POS_W-1:0]         position,
    input  logic signed [ial_pkg::WORD_W-1:0] word_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [ial_pkg::WORD_W-1:0] word_out,
    output logic [ial_pkg::STATUS_W-1:0]      status,
    output logic [ial_pkg::COUNT_W-1:0]       entry_count,
    output logic                              is_full,
    output logic                              is_empty
);
    import ial_pkg::*;

    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    logic [WORD_W-1:0]   entry_store_reg [DEPTH];
    logic [WORD_W-1:0]   rdata_reg;

    logic [FUNC_W-1:0]   func_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [WORD_W-1:0]   word_reg;
    act_t                act_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CAP_W-1:0]    cap_reg;
    logic [CMP_W-1:0]    idx_reg;

    // result of the request in progress, moved to the outputs at finish
    logic [WORD_W-1:0]   word_res_reg;
    logic [STATUS_W-1:0] status_res_reg;

    logic                out_valid_reg;
    logic [WORD_W-1:0]   word_out_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_now;
    logic [COUNT_W-1:0]  count_out_reg;
    logic                full_reg;
    logic                empty_reg;

    logic [CMP_W-1:0]    pos_c;
    logic [CMP_W-1:0]    cnt_c;
    logic [CMP_W-1:0]    cap_c;
    logic [CMP_W-1:0]    eff_cap;
    logic                full_now;
    logic                pos_in_list;
    act_t                act_now;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    // decode of the held request
    always_comb
    begin
        pos_c       = CMP_W'(pos_reg);
        cnt_c       = CMP_W'(count_reg);
        cap_c       = CMP_W'(cap_reg);
        eff_cap     = (cap_c > DEPTH_C) ? DEPTH_C : cap_c;
        full_now    = (cnt_c >= eff_cap) || (cnt_c >= DEPTH_C);
        pos_in_list = pos_c < cnt_c;
        act_now     = ACT_NONE;
        status_now  = ST_OK;
        unique case (func_reg)
            FN_APPEND:
            begin
                if (full_now) status_now = ST_OVERFLOW;
                else          act_now    = ACT_APPEND;
            end
            FN_INSERT:
            begin
                if (pos_c > cnt_c) status_now = ST_BAD_INDEX;
                else if (full_now) status_now = ST_OVERFLOW;
                else               act_now    = ACT_INSERT;
            end
            FN_GET:
            begin
                if (pos_in_list) act_now    = ACT_GET;
                else             status_now = ST_BAD_INDEX;
            end
            FN_EDIT:
            begin
                if (pos_in_list) act_now    = ACT_EDIT;
                else             status_now = ST_BAD_INDEX;
            end
            FN_DELETE:
            begin
                if (pos_in_list) act_now    = ACT_DELETE;
                else             status_now = ST_BAD_INDEX;
            end
            default:
            begin
                act_now = ACT_NONE;
            end
        endcase
    end

    assign dp_status.act      = act_now;
    assign dp_status.more     = (act_reg == ACT_INSERT) ? (idx_reg > pos_c)
                                                        : ((idx_reg + 1'b1) < cnt_c);
    assign dp_status.out_free = !out_valid_reg || out_ready;

    // memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[ADDR_W-1:0];
        mem_wdata = rdata_reg;
        priority if (cmd.exec && act_now == ACT_APPEND)
        begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[ADDR_W-1:0];
            mem_wdata = word_reg;
        end
        else if (cmd.exec && act_now == ACT_EDIT)
        begin
            mem_we    = 1'b1;
            mem_waddr = pos_reg[ADDR_W-1:0];
            mem_wdata = word_reg;
        end
        else if (cmd.sh_write)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.sh_tail && act_reg == ACT_INSERT)
        begin
            mem_we    = 1'b1;
            mem_waddr = pos_reg[ADDR_W-1:0];
            mem_wdata = word_reg;
        end

        mem_re    = (cmd.exec && act_now == ACT_GET) || cmd.sh_read;
        mem_raddr = pos_reg[ADDR_W-1:0];
        if (cmd.sh_read)
        begin
            if (act_reg == ACT_INSERT) mem_raddr = ADDR_W'(idx_reg - 1'b1);
            else                       mem_raddr = ADDR_W'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_store_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= entry_store_reg[mem_raddr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= func;
            pos_reg  <= position;
            word_reg <= word_in;
        end
        if (cmd.exec)
        begin
            act_reg        <= act_now;
            status_res_reg <= status_now;
            word_res_reg   <= (func_reg == FN_GET && !pos_in_list) ? '1 : '0;
            idx_reg        <= (act_now == ACT_INSERT) ? cnt_c : pos_c;
        end
        if (cmd.sh_write)
        begin
            idx_reg <= (act_reg == ACT_INSERT) ? idx_reg - 1'b1 : idx_reg + 1'b1;
        end
        if (cmd.get_cap)
        begin
            word_res_reg <= rdata_reg;
        end
        if (cmd.finish)
        begin
            word_out_reg  <= word_res_reg;
            status_reg    <= status_res_reg;
            count_out_reg <= COUNT_W'(count_reg);
            full_reg      <= cnt_c >= eff_cap;
            empty_reg     <= count_reg == '0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cfg_valid)
        begin
            count_next = '0;
        end
        else if (cmd.exec && act_now == ACT_APPEND)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.sh_tail)
        begin
            count_next = (act_reg == ACT_INSERT) ? count_reg + 1'b1 : count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign word_out    = word_out_reg;
    assign status      = status_reg;
    assign entry_count = count_out_reg;
    assign is_full     = full_reg;
    assign is_empty    = empty_reg;

    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_c <= eff_cap))
        else $error("fill count above capacity");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.latch, cmd.exec, cmd.get_cap, cmd.sh_read, cmd.sh_write,
                  cmd.sh_tail, cmd.finish}))
        else $error("overlapping datapath commands");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("result not presented after finish");

    a_shift_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sh_write |-> $past(cmd.sh_read))
        else $error("shift write without a preceding read");

endmodule

// ----- sv/indexed_array_list.sv -----
`timescale 1ns / 1ps
// indexed_array_list: top level, joins the controller and the datapath.
// Depends on ial_pkg, ial_ctrl and ial_dpath.

// Ordered list of up to 64 signed 32-bit words in a single-port memory, one
// request at a time. Append, edit, unknown codes and any rejected request go
// from decode straight to finish; get adds a read-capture state (registered
// memory read). Insert and delete move one entry at a time through the memory
// port, each move taking a shift read state and then a shift write state. A
// finished result sits in the output register, so a new request is taken
// while it waits; a second result stalls only if the first is still
// unclaimed. Writing cfg_data empties the list at once; the block has no
// clearing pass since only entries below the count are ever read.

module indexed_array_list
(
    input  logic                              clk,
    input  logic                              rst_n,
    // capacity register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ial_pkg::CAP_W-1:0]         cfg_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ial_pkg::FUNC_W-1:0]        func,
    input  logic [ial_pkg::POS_W-1:0]         position,
    input  logic signed [ial_pkg::WORD_W-1:0] word_in,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [ial_pkg::WORD_W-1:0] word_out,
    output logic [ial_pkg::STATUS_W-1:0]      status,
    output logic [ial_pkg::COUNT_W-1:0]       entry_count,
    output logic                              is_full,
    output logic                              is_empty
);
    import ial_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // user must land capacity writes only while idle; not enforced, all taken
    assign cfg_ready = 1'b1;

    // sequencer: decode, shift loop, result hand-off
    ial_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // storage, count and result registers
    ial_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .dp_status   (dp_status),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .func        (func),
        .position    (position),
        .word_in     (word_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .word_out    (word_out),
        .status      (status),
        .entry_count (entry_count),
        .is_full     (is_full),
        .is_empty    (is_empty)
    );

endmodule
